[rtl/next_permutation_engine_macros.svh]
// Assertion macros for the next permutation engine.
// Included by the top level; no other dependencies.
`ifndef NEXT_PERMUTATION_ENGINE_MACROS_SVH
`define NEXT_PERMUTATION_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define NPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("next_permutation_engine: implication check failed");
`define NPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next_permutation_engine: next-cycle check failed");
`else
`define NPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/npe_pkg.sv]
// Shared types for the next permutation engine: payload structs, controller
// states, and the command/status bundles between controller and datapath.
`default_nettype none
package npe_pkg;

  localparam int DATA_W = 16;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              end_of_seq;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_value;
    logic              out_last;
    logic              wrapped;
    logic              overflowed;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV_CMP,
    ST_SUC_RD,
    ST_SUC_CMP,
    ST_SWAP_WR,
    ST_REV_RD,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    WSRC_IN,
    WSRC_A,
    WSRC_B,
    WSRC_PIV
  } wsrc_t;

  typedef struct packed {
    logic  wr_en;
    wsrc_t wr_src;
    logic  rd_en;
    logic  piv_ld;
    logic  emit;
    logic  last;
    logic  wrapped;
    logic  overflowed;
  } cmd_t;

  typedef struct packed {
    logic a_lt_b;
    logic a_gt_piv;
  } sts_t;

endpackage
`default_nettype wire

[rtl/next_permutation_engine.sv]
// Top level of the next permutation engine: controller plus datapath.
// Depends on npe_pkg, npe_ctrl, npe_dp and next_permutation_engine_macros.svh.
`default_nettype none
`include "next_permutation_engine_macros.svh"
// Loads one element per cycle while busy is low; the element flagged end_of_seq
// closes the sequence of n stored elements and raises busy. The block then walks
// its element memory (one write port, two registered read ports): the pivot
// scan reads and compares one pair of positions at a time, the successor scan
// reads and compares one position at a time and then writes the swap, the
// suffix reversal reads each pair and writes its two ends, and the results
// leave at one per cycle, each on out_valid for exactly one cycle. The receiver
// cannot stall, so results must be taken as they appear. busy drops during the
// cycle that carries the final transfer, and a new sequence may start loading
// then. Elements beyond MAX_LEN are dropped and reported through the overflowed
// flag on every result of that sequence.
module next_permutation_engine #(
  parameter int MAX_LEN     = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  npe_pkg::in_t   in_data,
  output logic           out_valid,
  output npe_pkg::out_t  out_data
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  npe_pkg::cmd_t cmd;
  npe_pkg::sts_t sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_a_addr;
  logic [AW-1:0] rd_b_addr;

  npe_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .end_of_seq (in_data.end_of_seq),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (rd_b_addr)
  );

  npe_dp #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .in_value  (in_data.value),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a closing transfer always starts the rearrangement
  `NPE_ASSERT_NEXT(a_close_busy, clk, rst_n, start && !busy && in_data.end_of_seq, busy)
  // the final result frees the block, any earlier one finds it still emitting
  `NPE_ASSERT_IMPL(a_last_idle, clk, rst_n, out_valid && out_data.out_last, !busy)
  `NPE_ASSERT_IMPL(a_mid_busy, clk, rst_n, out_valid && !out_data.out_last, busy && cmd.emit)
  // memory never sees a write and a read in the same cycle
  `NPE_ASSERT_IMPL(a_port_excl, clk, rst_n, cmd.wr_en, !cmd.rd_en)

endmodule
`default_nettype wire

[rtl/npe_dp.sv]
// Datapath of the next permutation engine: element memory with two
// registered read ports, pivot register, comparators and result register.
// Depends on npe_pkg.
`default_nettype none
module npe_dp #(
  parameter int MAX_LEN     = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  npe_pkg::cmd_t                         cmd,
  input  wire [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
  input  wire [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_a_addr,
  input  wire [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_b_addr,
  input  wire [npe_pkg::DATA_W-1:0]             in_value,
  output npe_pkg::sts_t                         sts,
  output logic                                  out_valid,
  output npe_pkg::out_t                         out_data
);

  localparam int EW = (VALUE_WIDTH > npe_pkg::DATA_W) ? VALUE_WIDTH : npe_pkg::DATA_W;

  logic [VALUE_WIDTH-1:0] mem [MAX_LEN];
  logic [VALUE_WIDTH-1:0] rd_a_r;
  logic [VALUE_WIDTH-1:0] rd_b_r;
  logic [VALUE_WIDTH-1:0] piv_r;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [EW-1:0]          in_ext;
  logic [EW-1:0]          out_ext;
  logic                   out_valid_r;
  logic                   last_r;
  logic                   wrapped_r;
  logic                   ovf_r;

  assign in_ext  = EW'(in_value);
  assign out_ext = EW'(rd_a_r);

  always_comb begin
    case (cmd.wr_src)
      npe_pkg::WSRC_IN:  wr_data = in_ext[VALUE_WIDTH-1:0];
      npe_pkg::WSRC_A:   wr_data = rd_a_r;
      npe_pkg::WSRC_B:   wr_data = rd_b_r;
      npe_pkg::WSRC_PIV: wr_data = piv_r;
      default:           wr_data = rd_a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
    if (cmd.piv_ld) begin
      piv_r <= rd_a_r;
    end
  end

  // result flags ride along with the read issued in the emit state
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_r    <= cmd.last;
      wrapped_r <= cmd.wrapped;
      ovf_r     <= cmd.overflowed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign sts.a_lt_b   = rd_a_r < rd_b_r;
  assign sts.a_gt_piv = rd_a_r > piv_r;

  assign out_valid           = out_valid_r;
  assign out_data.out_value  = out_ext[npe_pkg::DATA_W-1:0];
  assign out_data.out_last   = last_r;
  assign out_data.wrapped    = wrapped_r;
  assign out_data.overflowed = ovf_r;

endmodule
`default_nettype wire

[rtl/npe_ctrl.sv]
// Controller of the next permutation engine: load counter, pivot and
// successor scans, suffix reversal and output sequencing.
// Depends on npe_pkg.
`default_nettype none
module npe_ctrl #(
  parameter int MAX_LEN = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire                                   end_of_seq,
  input  npe_pkg::sts_t                         sts,
  output logic                                  busy,
  output npe_pkg::cmd_t                         cmd,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_a_addr,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] rd_b_addr
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  npe_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          wrap_r, wrap_nxt;
  logic [AW-1:0] p_r, p_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic          room;
  logic [CW-1:0] n_close;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] close_idx;

  assign room      = count_r < CW'(MAX_LEN);
  assign n_close   = room ? count_r + CW'(1) : count_r;
  assign last_idx  = AW'(count_r - CW'(1));
  assign close_idx = AW'(n_close - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npe_pkg::ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      wrap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r  <= p_nxt;
    k_r  <= k_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    i_r  <= i_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    wrap_nxt  = wrap_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    cmd       = '0;
    wr_addr   = count_r[AW-1:0];
    rd_a_addr = i_r;
    rd_b_addr = hi_r;
    busy      = state_r != npe_pkg::ST_IDLE;

    case (state_r)
      npe_pkg::ST_IDLE: begin
        if (start) begin
          if (room) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = npe_pkg::WSRC_IN;
            count_nxt  = n_close;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (end_of_seq) begin
            if (n_close <= CW'(1)) begin
              wrap_nxt  = 1'b1;
              i_nxt     = '0;
              state_nxt = npe_pkg::ST_EMIT;
            end else begin
              p_nxt     = close_idx;
              state_nxt = npe_pkg::ST_PIV_RD;
            end
          end
        end
      end

      npe_pkg::ST_PIV_RD: begin
        cmd.rd_en = 1'b1;
        rd_a_addr = p_r - AW'(1);
        rd_b_addr = p_r;
        state_nxt = npe_pkg::ST_PIV_CMP;
      end

      npe_pkg::ST_PIV_CMP: begin
        if (sts.a_lt_b) begin
          // pivot sits left of p; hold its value for the successor search
          cmd.piv_ld = 1'b1;
          p_nxt      = p_r - AW'(1);
          k_nxt      = last_idx;
          state_nxt  = npe_pkg::ST_SUC_RD;
        end else if (p_r == AW'(1)) begin
          wrap_nxt  = 1'b1;
          lo_nxt    = '0;
          hi_nxt    = last_idx;
          state_nxt = npe_pkg::ST_REV_RD;
        end else begin
          p_nxt     = p_r - AW'(1);
          state_nxt = npe_pkg::ST_PIV_RD;
        end
      end

      npe_pkg::ST_SUC_RD: begin
        cmd.rd_en = 1'b1;
        rd_a_addr = k_r;
        state_nxt = npe_pkg::ST_SUC_CMP;
      end

      npe_pkg::ST_SUC_CMP: begin
        if (sts.a_gt_piv) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = npe_pkg::WSRC_A;
          wr_addr    = p_r;
          state_nxt  = npe_pkg::ST_SWAP_WR;
        end else begin
          k_nxt     = k_r - AW'(1);
          state_nxt = npe_pkg::ST_SUC_RD;
        end
      end

      npe_pkg::ST_SWAP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = npe_pkg::WSRC_PIV;
        wr_addr    = k_r;
        lo_nxt     = p_r + AW'(1);
        hi_nxt     = last_idx;
        state_nxt  = npe_pkg::ST_REV_RD;
      end

      npe_pkg::ST_REV_RD: begin
        if (lo_r < hi_r) begin
          cmd.rd_en = 1'b1;
          rd_a_addr = lo_r;
          rd_b_addr = hi_r;
          state_nxt = npe_pkg::ST_REV_WR_LO;
        end else begin
          i_nxt     = '0;
          state_nxt = npe_pkg::ST_EMIT;
        end
      end

      npe_pkg::ST_REV_WR_LO: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = npe_pkg::WSRC_B;
        wr_addr    = lo_r;
        state_nxt  = npe_pkg::ST_REV_WR_HI;
      end

      npe_pkg::ST_REV_WR_HI: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = npe_pkg::WSRC_A;
        wr_addr    = hi_r;
        lo_nxt     = lo_r + AW'(1);
        hi_nxt     = hi_r - AW'(1);
        state_nxt  = npe_pkg::ST_REV_RD;
      end

      npe_pkg::ST_EMIT: begin
        cmd.rd_en      = 1'b1;
        cmd.emit       = 1'b1;
        cmd.last       = i_r == last_idx;
        cmd.wrapped    = wrap_r;
        cmd.overflowed = ovf_r;
        rd_a_addr      = i_r;
        if (i_r == last_idx) begin
          // drop the sequence state; the final transfer shows next cycle
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          wrap_nxt  = 1'b0;
          state_nxt = npe_pkg::ST_IDLE;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end

      default: begin
        state_nxt = npe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[bench/tb_next_permutation_engine.sv]
`timescale 1ns / 1ps
// Self-checking bench for next_permutation_engine: streams element sequences,
// predicts each next lexicographic permutation and compares every result.
// Depends on npe_pkg and the next_permutation_engine RTL only.
module tb_next_permutation_engine;

  localparam int CAP         = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 150;
  localparam int MAX_REPORTS = 10;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  npe_pkg::in_t  in_data;
  logic          out_valid;
  npe_pkg::out_t out_data;

  // predictor state: elements of the open sequence and permutations in flight
  logic [npe_pkg::DATA_W-1:0] stored_vals [CAP];
  int                         stored_len  = 0;
  bit                         drop_seen   = 1'b0;
  npe_pkg::out_t              perm_expected [$];

  int  err_count   = 0;
  int  items_sent  = 0;
  int  idle_cycles = 0;
  bit  idle_allowed = 1'b1;
  bit  gaps_on      = 1'b0;

  next_permutation_engine #(
    .MAX_LEN     (CAP),
    .VALUE_WIDTH (npe_pkg::DATA_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Rearrange the closed sequence into its next permutation and queue the results.
  function automatic void predict_next_perm();
    logic [npe_pkg::DATA_W-1:0] a [CAP];
    logic [npe_pkg::DATA_W-1:0] t;
    int            n;
    int            p;
    int            k;
    int            lo;
    int            hi;
    bit            wrap;
    npe_pkg::out_t r;
    a    = stored_vals;
    n    = stored_len;
    wrap = 1'b1;
    lo   = 0;
    hi   = n - 1;
    if (n >= 2) begin
      p = n - 1;
      while (p > 0 && !(a[p-1] < a[p])) p--;
      if (p > 0) begin
        wrap = 1'b0;
        p    = p - 1;
        k    = n - 1;
        // suffix is non-increasing: rightmost larger value is the least larger one
        while (a[k] <= a[p]) k--;
        t    = a[p];
        a[p] = a[k];
        a[k] = t;
        lo   = p + 1;
      end
    end
    while (lo < hi) begin
      t     = a[lo];
      a[lo] = a[hi];
      a[hi] = t;
      lo++;
      hi--;
    end
    for (int i = 0; i < n; i++) begin
      r.out_value  = a[i];
      r.out_last   = (i == n - 1);
      r.wrapped    = wrap;
      r.overflowed = drop_seen;
      perm_expected.push_back(r);
    end
  endfunction

  function automatic void check_result(npe_pkg::out_t got);
    npe_pkg::out_t want;
    if (perm_expected.size() == 0) begin
      note_failure($sformatf("unexpected result value=%h last=%b wrapped=%b overflowed=%b",
                             got.out_value, got.out_last, got.wrapped, got.overflowed));
      return;
    end
    want = perm_expected.pop_front();
    if (got.out_value !== want.out_value || got.out_last !== want.out_last ||
        got.wrapped !== want.wrapped || got.overflowed !== want.overflowed) begin
      note_failure($sformatf({"expected value=%h last=%b wrapped=%b overflowed=%b, ",
                              "got value=%h last=%b wrapped=%b overflowed=%b"},
                             want.out_value, want.out_last, want.wrapped, want.overflowed,
                             got.out_value, got.out_last, got.wrapped, got.overflowed));
    end
  endfunction

  // Sample at the rising edge: check results first, then absorb an accepted element.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) check_result(out_data);
      if (start && !busy) begin
        if (stored_len < CAP) begin
          stored_vals[stored_len] = in_data.value;
          stored_len++;
        end else begin
          drop_seen = 1'b1;
        end
        if (in_data.end_of_seq) begin
          predict_next_perm();
          stored_len = 0;
          drop_seen  = 1'b0;
        end
      end
      if (out_valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one element and hold it until the transfer happens.
  task automatic send_elem(input logic [npe_pkg::DATA_W-1:0] v, input logic eos);
    int           gap;
    npe_pkg::in_t item;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      start   <= 1'b0;
      in_data <= npe_pkg::in_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    item.value      = v;
    item.end_of_seq = eos;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_list(input logic [npe_pkg::DATA_W-1:0] vals [$]);
    foreach (vals[i]) send_elem(vals[i], i == vals.size() - 1);
  endtask

  // Build a sequence of the given length in one of several value styles.
  task automatic send_random_seq(input int len);
    logic [npe_pkg::DATA_W-1:0] vals [$];
    int   style;
    int   cur;
    int   step;
    style = $urandom_range(0, 9);
    cur   = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      if (style < 4) begin
        vals.push_back(16'($urandom_range(0, 65535)));
      end else if (style < 7) begin
        // tiny alphabet: plenty of ties around pivot and successor
        vals.push_back(16'($urandom_range(0, 3)));
      end else if (style < 9) begin
        // non-increasing run: greatest permutation, must wrap
        step = $urandom_range(0, 6000);
        if (step > cur) step = cur;
        cur -= step;
        vals.push_back(16'(cur));
      end else begin
        vals.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      end
    end
    gaps_on = idle_allowed && ($urandom_range(0, 2) != 0);
    send_list(vals);
  endtask

  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(CAP + 1, CAP + 6);
    if (sel == 1) return $urandom_range(1, 3);
    return $urandom_range(1, CAP);
  endfunction

  task automatic test_single_element();
    send_list('{16'hFFFF});
  endtask

  task automatic test_equal_values();
    send_list('{16'd7, 16'd7});
    // tied successor candidates: the rightmost one must be taken
    send_list('{16'd1, 16'd3, 16'd3});
  endtask

  task automatic test_descending_wrap();
    send_list('{16'hFFFF, 16'h8000, 16'h0000});
  endtask

  task automatic test_capacity_overflow();
    logic [npe_pkg::DATA_W-1:0] vals [$];
    for (int i = 0; i < CAP + 1; i++) begin
      vals.push_back((i % 2) ? 16'hFFFF : 16'(i * 16'h1111));
    end
    send_list(vals);
  endtask

  task automatic test_random_sequences();
    while (items_sent < 380) send_random_seq(pick_len());
  endtask

  task automatic test_back_to_back();
    idle_allowed = 1'b0;
    gaps_on      = 1'b0;
    while (items_sent < 420) send_random_seq(pick_len());
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_equal_values();
    test_descending_wrap();
    test_capacity_overflow();
    test_random_sequences();
    test_back_to_back();

    @(negedge clk);
    start <= 1'b0;
    while (perm_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && perm_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
